FILE: hdl/tcon_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcon_pkg
// shared opcodes, character codes, cell constants and control types of the
// text console character engine
// ----------------------------------------------------------------------------
package tcon_pkg;

    localparam int OPCODE_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;

    localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [7:0]        ATTR_WHITE_ON_BLACK = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_WHITE_ON_BLACK, CH_SPACE};

    // side effects of one put beat
    typedef struct packed {
        logic store;    // printable byte goes into the cell under the cursor
        logic scroll;   // cursor ran off the last row
    } t_put_flags;

endpackage : tcon_pkg
`default_nettype wire

FILE: hdl/tcon_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcon_ram
// screen cell store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tcon_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule : tcon_ram
`default_nettype wire

FILE: hdl/tcon_cursor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcon_cursor
// next cursor position for one put byte, with wrap and scroll detection
// ----------------------------------------------------------------------------
module tcon_cursor
    import tcon_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4,
    parameter int COL_W    = 7,
    parameter int ROW_W    = 5
) (
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [CHAR_W-1:0] i_char,
    output logic      [COL_W-1:0]  o_col,
    output logic      [ROW_W-1:0]  o_row,
    output t_put_flags             o_flags
);

    localparam int TAB_ENTRIES = 2 ** COL_W;

    // next tab stop per column, clamped to COLUMNS when it runs off the line
    logic [COL_W:0] tab_lut [TAB_ENTRIES];

    for (genvar g = 0; g < TAB_ENTRIES; g++) begin : g_tab
        localparam int TN = (g / TAB_STOP + 1) * TAB_STOP;
        localparam int TC = (TN >= COLUMNS) ? COLUMNS : TN;
        assign tab_lut[g] = (COL_W+1)'(TC);
    end

    logic [COL_W:0] col_step;
    logic           printable;
    logic           line_feed;
    logic           advance;

    assign printable = (i_char >= CH_SPACE) && (i_char <= CH_TILDE);

    always_comb begin
        col_step  = {1'b0, i_col};
        line_feed = 1'b0;
        priority if (printable) begin
            col_step = {1'b0, i_col} + (COL_W+1)'(1);
        end else if (i_char == CH_BS) begin
            if (i_col != '0) begin
                col_step = {1'b0, i_col} - (COL_W+1)'(1);
            end
        end else if (i_char == CH_TAB) begin
            col_step = tab_lut[i_col];
        end else if (i_char == CH_LF) begin
            col_step  = '0;
            line_feed = 1'b1;
        end else if (i_char == CH_CR) begin
            col_step = '0;
        end else begin
            // any other byte leaves the cursor where it is
        end
    end

    always_comb begin
        advance = line_feed;
        o_col   = col_step[COL_W-1:0];
        if (col_step >= (COL_W+1)'(COLUMNS)) begin
            o_col   = '0;
            advance = 1'b1;
        end
    end

    always_comb begin
        o_row          = i_row;
        o_flags.store  = printable;
        o_flags.scroll = 1'b0;
        if (advance) begin
            if (i_row == ROW_W'(ROWS - 1)) begin
                o_flags.scroll = 1'b1;
            end else begin
                o_row = i_row + ROW_W'(1);
            end
        end
    end

endmodule : tcon_cursor
`default_nettype wire

FILE: hdl/text_console_char_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_engine
// text screen of attribute/character cells with a put, read and clear port
// ----------------------------------------------------------------------------
// usage
//   - a command beat is taken at a rising edge with start high and busy low;
//     i_opcode selects put character, read cell or clear screen
//   - every command gives one result beat: o_done high for one cycle with
//     o_cursor_pos (row*COLUMNS+column, low 11 bits) and o_cell_data (the
//     cell for a read in range, 0 otherwise); the receiver cannot stall it
//   - put without scroll, read and unused opcode: result in the cycle after
//     the command edge, and busy stays low, so one command a cycle
//   - put that runs off the last row: the store is copied up one line through
//     the memory read port and the bottom line blanked, one cell a cycle
//     (blanking waits for the last copy write); busy for the sweep, result
//     in the same cycle as busy drops
//   - clear: one blank write a cycle while busy, result in the same cycle
//     as busy drops
//   - reset: cursor homed and a blanking pass over every cell runs
//     with busy high; no result beat comes out of it
//   - throughput is set by the single write port of the cell memory
// ----------------------------------------------------------------------------
module text_console_char_engine
    import tcon_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic [INDEX_W-1:0]  i_cell_index,
    output logic                     o_done,
    output logic      [POS_W-1:0]    o_cursor_pos,
    output logic      [CELL_W-1:0]   o_cell_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    // wide enough for the full linear position and for an 11-bit index
    localparam int PW         = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,     // move each line up by one
        S_BLANK     // write blank cells up to the end of the store
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_ptr;
    logic               r_cp_vld;   // copy write pending from last read
    logic [ADDR_W-1:0]  r_cp_addr;
    logic               r_report;   // sweep ends with a result beat
    logic               r_done;
    logic               r_rd_ok;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    logic [COL_W-1:0]   put_col;
    logic [ROW_W-1:0]   put_row;
    t_put_flags         put_flags;

    logic               accept;
    logic [PW-1:0]      pos_ext;
    logic               idx_ok;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_q;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign pos_ext = PW'(r_row) * PW'(COLUMNS) + PW'(r_col);
    assign idx_ok  = PW'(i_cell_index) < PW'(CELL_COUNT);

    assign o_done       = r_done;
    assign o_cursor_pos = pos_ext[POS_W-1:0];
    assign o_cell_data  = r_rd_ok ? ram_q : '0;

    tcon_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .COL_W    (COL_W),
        .ROW_W    (ROW_W)
    ) u_cursor (
        .i_col   (r_col),
        .i_row   (r_row),
        .i_char  (i_char_code),
        .o_col   (put_col),
        .o_row   (put_row),
        .o_flags (put_flags)
    );

    // one write port: pending copy first, then blanking, then a stored char
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = BLANK_CELL;
        if (r_cp_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_q;
        end else if (r_state == S_BLANK) begin
            ram_we    = 1'b1;
        end else if (accept && (i_opcode == OP_PUT) && put_flags.store) begin
            ram_we    = 1'b1;
            ram_waddr = pos_ext[ADDR_W-1:0];
            ram_wdata = {ATTR_WHITE_ON_BLACK, i_char_code};
        end
    end

    // read port serves the copy sweep and read commands
    assign ram_re    = (r_state == S_COPY) || (accept && (i_opcode == OP_READ));
    assign ram_raddr = (r_state == S_COPY) ? r_ptr : ADDR_W'(i_cell_index);

    tcon_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BLANK;
            r_ptr    <= '0;
            r_cp_vld <= 1'b0;
            r_report <= 1'b0;
            r_done   <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_done   <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_cp_vld <= (r_state == S_COPY);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_opcode == OP_PUT) begin
                            r_col <= put_col;
                            r_row <= put_row;
                            if (put_flags.scroll) begin
                                r_state  <= S_COPY;
                                r_ptr    <= ADDR_W'(COLUMNS);
                                r_report <= 1'b1;
                            end else begin
                                r_done <= 1'b1;
                            end
                        end else if (i_opcode == OP_CLEAR) begin
                            r_col    <= '0;
                            r_row    <= '0;
                            r_state  <= S_BLANK;
                            r_ptr    <= '0;
                            r_report <= 1'b1;
                        end else if (i_opcode == OP_READ) begin
                            r_done  <= 1'b1;
                            r_rd_ok <= idx_ok;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_COPY: begin
                    r_cp_addr <= r_ptr - ADDR_W'(COLUMNS);
                    if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                        r_state <= S_BLANK;
                        r_ptr   <= ADDR_W'(CELL_COUNT - COLUMNS);
                    end else begin
                        r_ptr <= r_ptr + ADDR_W'(1);
                    end
                end
                S_BLANK: begin
                    // hold while the last copy write owns the port
                    if (!r_cp_vld) begin
                        if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                            r_state <= S_IDLE;
                            r_done  <= r_report;
                        end else begin
                            r_ptr <= r_ptr + ADDR_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule : text_console_char_engine
`default_nettype wire

FILE: hdl/tcon_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcon_chk
// port-level checks of the text console character engine
// ----------------------------------------------------------------------------
module tcon_chk
    import tcon_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                o_done,
    input  wire logic [POS_W-1:0]    o_cursor_pos,
    input  wire logic [CELL_W-1:0]   o_cell_data
);

    // a taken command either answers next cycle or starts a sweep
    a_cmd_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("command beat neither answered nor started a sweep");

    // a result beat never overlaps a sweep
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // cell data only carries a value on a result beat
    a_data_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_cell_data == '0))
        else $error("cell data nonzero outside a result beat");

    // cursor only moves on a taken command
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(start && !busy)) |-> $stable(o_cursor_pos))
        else $error("cursor moved without a command beat");

endmodule : tcon_chk

bind text_console_char_engine tcon_chk u_tcon_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_cursor_pos (o_cursor_pos),
    .o_cell_data  (o_cell_data)
);
`default_nettype wire
